@@ sv/ptm_pkg.sv @@
// ----------------------------------------------------------------------------
// ptm_pkg - shared types and constants for the page table mapper
// Entry layout, status and mode codes, and the level index decode.
// ----------------------------------------------------------------------------
`default_nettype none

package ptm_pkg;

    typedef logic [63:0] entry_t;

    localparam logic       MODE_MAP    = 1'b0;
    localparam logic       MODE_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_POOL_FULL  = 2'd1;
    localparam logic [1:0] STATUS_NOT_MAPPED = 2'd2;

    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned IDX_BITS   = 9;
    localparam int unsigned FRAME_BITS = 40;

    // present + writable for a table link
    localparam entry_t LINK_FLAGS = 64'h0000_0000_0000_0003;

    // 9-bit index of a walk level: level 3 is the root
    function automatic logic [IDX_BITS-1:0] level_index(input logic [47:0] va,
                                                        input logic [1:0]  level);
        logic [IDX_BITS-1:0] idx;
        unique case (level)
            2'd3:    idx = va[47:39];
            2'd2:    idx = va[38:30];
            2'd1:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ sv/ptm_store.sv @@
// ----------------------------------------------------------------------------
// ptm_store - table pool storage
// Single-port RAM, one write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_store #(
    parameter int unsigned DEPTH = 32768,
    parameter int unsigned AW    = 15
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire ptm_pkg::entry_t  wdata,
    output ptm_pkg::entry_t       rdata
);

    ptm_pkg::entry_t mem [DEPTH];
    ptm_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/four_level_page_table_mapper.sv @@
// ----------------------------------------------------------------------------
// four_level_page_table_mapper - four-level page walk over a table pool
//
//  channel   handshake            payload
//  request   start / busy         mode, virt_addr, phys_addr, entry_flags
//  result    done (one cycle)     status, frame_number
//
// Each level passes a read state and an evaluate state on the single RAM port,
// which sets the time per request; a map writes its leaf entry in the last
// read state, and a walk that stops early is shorter. After reset the RAM is
// swept to zero, one entry a cycle, over all TABLE_POOL*512 entries with busy
// high. busy stays high from the accepted transfer until done; results cannot
// be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_mapper #(
    parameter int unsigned TABLE_POOL = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic         mode,
    input  wire logic [47:0]  virt_addr,
    input  wire logic [51:0]  phys_addr,
    input  wire logic [8:0]   entry_flags,
    output logic              done,
    output logic [1:0]        status,
    output logic [39:0]       frame_number
);

    localparam int unsigned SW    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int unsigned NW    = $clog2(TABLE_POOL + 1);
    localparam int unsigned AW    = SW + ptm_pkg::IDX_BITS;
    localparam int unsigned DEPTH = TABLE_POOL * 512;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EVAL  = 2'd3;

    logic [1:0]    state_reg,     state_next;
    logic [AW-1:0] clr_cnt_reg,   clr_cnt_next;
    logic [NW-1:0] next_free_reg, next_free_next;
    logic [1:0]    level_reg,     level_next;
    logic [SW-1:0] table_reg,     table_next;
    logic          done_reg,      done_next;
    logic [1:0]    status_reg,    status_next;
    logic [39:0]   frame_reg,     frame_next;

    // request latch, no reset
    logic          mode_reg;
    logic [47:0]   va_reg;
    logic [39:0]   pfn_reg;
    logic [8:0]    flags_reg;

    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    ptm_pkg::entry_t mem_wdata;
    ptm_pkg::entry_t mem_rdata;

    logic [AW-1:0]   walk_addr;
    logic            entry_ok;
    ptm_pkg::entry_t leaf_entry;
    ptm_pkg::entry_t link_entry;

    ptm_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign walk_addr  = {table_reg, ptm_pkg::level_index(va_reg, level_reg)};
    assign entry_ok   = mem_rdata[0] &&
                        (mem_rdata[51:12] < ptm_pkg::FRAME_BITS'(TABLE_POOL));
    assign leaf_entry = {12'd0, pfn_reg, 3'd0, flags_reg[8], 1'b0, flags_reg[6:0]};
    assign link_entry = (ptm_pkg::entry_t'(next_free_reg[SW-1:0])
                         << ptm_pkg::PAGE_SHIFT) | ptm_pkg::LINK_FLAGS;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        next_free_next = next_free_reg;
        level_next     = level_reg;
        table_next     = table_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        frame_next     = frame_reg;
        mem_we         = 1'b0;
        mem_addr       = walk_addr;
        mem_wdata      = leaf_entry;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_cnt_reg;
                mem_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    level_next = 2'd3;
                    table_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (level_reg == 2'd0 && mode_reg == ptm_pkg::MODE_MAP)
                begin
                    // leaf write needs no read first
                    mem_we      = 1'b1;
                    done_next   = 1'b1;
                    status_next = ptm_pkg::STATUS_OK;
                    frame_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (level_reg == 2'd0)
                begin
                    // lookup leaf
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (mem_rdata[0])
                    begin
                        status_next = ptm_pkg::STATUS_OK;
                        frame_next  = mem_rdata[51:12];
                    end
                    else
                    begin
                        status_next = ptm_pkg::STATUS_NOT_MAPPED;
                        frame_next  = '0;
                    end
                end
                else if (entry_ok)
                begin
                    table_next = mem_rdata[12 +: SW];
                    level_next = level_reg - 1'b1;
                    state_next = S_READ;
                end
                else if (mode_reg == ptm_pkg::MODE_LOOKUP)
                begin
                    done_next   = 1'b1;
                    status_next = ptm_pkg::STATUS_NOT_MAPPED;
                    frame_next  = '0;
                    state_next  = S_IDLE;
                end
                else if (next_free_reg == NW'(TABLE_POOL))
                begin
                    done_next   = 1'b1;
                    status_next = ptm_pkg::STATUS_POOL_FULL;
                    frame_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    // link a fresh table; the sweep left it zeroed
                    mem_we         = 1'b1;
                    mem_wdata      = link_entry;
                    table_next     = next_free_reg[SW-1:0];
                    next_free_next = next_free_reg + 1'b1;
                    level_next     = level_reg - 1'b1;
                    state_next     = S_READ;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            next_free_reg <= NW'(1);
            level_reg     <= '0;
            table_reg     <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ptm_pkg::STATUS_OK;
            frame_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            next_free_reg <= next_free_next;
            level_reg     <= level_next;
            table_reg     <= table_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            frame_reg     <= frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            mode_reg  <= mode;
            va_reg    <= virt_addr;
            pfn_reg   <= phys_addr[51:12];
            flags_reg <= entry_flags;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign frame_number = frame_reg;

`ifndef NO_ASSERTIONS
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg >= NW'(1)) && (next_free_reg <= NW'(TABLE_POOL)))
        else $error("free table counter out of range");

    a_free_only_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EVAL) |=> $stable(next_free_reg))
        else $error("free table counter moved outside a walk step");

    a_fail_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ptm_pkg::STATUS_OK) |-> (frame_number == '0))
        else $error("failed request carries a frame number");

    a_pool_full_map: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ptm_pkg::STATUS_POOL_FULL) |-> (mode_reg == ptm_pkg::MODE_MAP))
        else $error("pool_full reported on a lookup");
`endif

endmodule

`default_nettype wire
